[hw/rtl/sv39_ptw_pkg.sv]
// Shared types and constants of the Sv39 page-table walker.
package sv39_ptw_pkg;

	// Size of the table memory window.
	localparam int TABLE_PAGES      = 8;
	localparam int ENTRIES_PER_PAGE = 512;
	localparam int MEM_DEPTH        = TABLE_PAGES * ENTRIES_PER_PAGE;
	localparam int MEM_AW           = $clog2(MEM_DEPTH);
	localparam int PG_W             = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;

	// Field widths.
	localparam int PPN_W   = 44;
	localparam int VA_W    = 39;
	localparam int PA_W    = 56;
	localparam int SLOT_W  = 12;
	localparam int PTE_W   = 64;
	localparam int VPN_W   = 9;
	localparam int LVL_W   = 2;
	localparam int CFG_IDX_W = 1;

	// Operation codes.
	localparam logic OP_WRITE     = 1'b0;
	localparam logic OP_TRANSLATE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_PPN    = 1'b1;

	// Walk levels.
	localparam logic [LVL_W-1:0] LVL_GIGA = 2'd2;
	localparam logic [LVL_W-1:0] LVL_MEGA = 2'd1;
	localparam logic [LVL_W-1:0] LVL_PAGE = 2'd0;

	// Walk sequencer states.
	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_LOOKUP = 5'b00100,
		S_EVAL   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

endpackage

[hw/rtl/sv39_ptw_ram.sv]
// Generic single-port RAM with a registered read port.
module sv39_ptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                             wdata,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[hw/rtl/sv39_page_table_walker.sv]
// Top level of the Sv39 page-table walker with its private table memory.
// After reset the memory is zeroed one entry per cycle, all MEM_DEPTH entries (4096 with
// eight pages), and no input item is accepted until that pass ends. A write item goes
// from the idle state straight to the done state. A translate item passes a lookup state
// (window check) and an eval state (entry read) per level; a failing check goes straight
// to the done state. The next item is accepted in the cycle after the result moves out.
module sv39_page_table_walker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Configuration writes.
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [sv39_ptw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sv39_ptw_pkg::PPN_W-1:0]          cfg_data,
	// Input items.
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    opcode,
	input  logic [sv39_ptw_pkg::VA_W-1:0]           virt_addr,
	input  logic [sv39_ptw_pkg::SLOT_W-1:0]         entry_slot,
	input  logic [sv39_ptw_pkg::PTE_W-1:0]          entry_value,
	// Result items.
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [sv39_ptw_pkg::PA_W-1:0]           phys_addr,
	output logic                                    fault,
	output logic [sv39_ptw_pkg::LVL_W-1:0]          leaf_level
);

	import sv39_ptw_pkg::*;

	// Control state.
	state_t              state_q;
	logic [MEM_AW-1:0]   clr_cnt_q;
	logic [LVL_W-1:0]    level_q;
	logic                out_valid_q;

	// Configuration registers.
	logic [PPN_W-1:0]    window_base_q;
	logic [PPN_W-1:0]    root_ppn_q;

	// Walk payload and the pending result.
	logic [VA_W-1:0]     va_q;
	logic [PPN_W-1:0]    table_q;
	logic [PA_W-1:0]     res_pa_q;
	logic                res_fault_q;
	logic [LVL_W-1:0]    res_lvl_q;

	// Output register.
	logic [PA_W-1:0]     phys_addr_q;
	logic                fault_q;
	logic [LVL_W-1:0]    leaf_level_q;

	// Memory port.
	logic                mem_we;
	logic [MEM_AW-1:0]   mem_addr;
	logic [PTE_W-1:0]    mem_wdata;
	logic [PTE_W-1:0]    mem_rdata;

	// Shared window unit and entry decode.
	logic [PPN_W:0]      win_diff;
	logic [PPN_W-1:0]    win_off;
	logic                in_win;
	logic [VPN_W-1:0]    vpn;
	logic [MEM_AW-1:0]   rd_addr;
	logic                slot_ok;
	logic                ent_v;
	logic                ent_leaf;
	logic [PA_W-1:0]     leaf_pa;
	logic                in_fire;
	logic                out_load;
	logic                clr_last;

	assign in_fire   = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign clr_last  = (clr_cnt_q == MEM_AW'(MEM_DEPTH - 1));

	// The window subtractor of the walk: it places the current table page in the
	// window. A borrow means the page lies below the window base.
	assign win_diff = {1'b0, table_q} - {1'b0, window_base_q};
	assign win_off  = win_diff[PPN_W-1:0];
	assign in_win   = !win_diff[PPN_W] && (win_off < PPN_W'(TABLE_PAGES));

	// Nine bits of the virtual address index each level.
	always_comb begin
		case (level_q)
			LVL_GIGA: vpn = va_q[38:30];
			LVL_MEGA: vpn = va_q[29:21];
			default:  vpn = va_q[20:12];
		endcase
	end

	assign rd_addr = MEM_AW'({win_off[PG_W-1:0], vpn});
	assign slot_ok = (32'(entry_slot) < 32'(MEM_DEPTH));

	// Entry decode. A leaf keeps the PPN bits above the page size and takes the
	// virtual address bits below it; a misaligned superpage does not fault.
	assign ent_v    = mem_rdata[0];
	assign ent_leaf = |mem_rdata[3:1];

	always_comb begin
		case (level_q)
			LVL_GIGA: leaf_pa = {mem_rdata[53:28], va_q[29:0]};
			LVL_MEGA: leaf_pa = {mem_rdata[53:19], va_q[20:0]};
			default:  leaf_pa = {mem_rdata[53:10], va_q[11:0]};
		endcase
	end

	// Memory port: the clearing pass and table writes use it as a write port,
	// the walk reads one entry per level through it.
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = rd_addr;
		mem_wdata = entry_value;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_cnt_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				mem_we   = in_fire && (opcode == OP_WRITE) && slot_ok;
				mem_addr = MEM_AW'(entry_slot);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	sv39_ptw_ram #(
		.WIDTH (PTE_W),
		.DEPTH (MEM_DEPTH)
	) u_table_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Configuration registers take a beat in any state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q <= '0;
			root_ppn_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_BASE: window_base_q <= cfg_data;
				REG_ROOT_PPN:    root_ppn_q    <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Walk sequencer. The walk leaves for the done state on a fault, on a leaf,
	// or on a pointer at the last level; otherwise it descends one level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			level_q     <= LVL_GIGA;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
					if (clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						level_q <= LVL_GIGA;
						state_q <= (opcode == OP_WRITE) ? S_DONE : S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					state_q <= in_win ? S_EVAL : S_DONE;
				end
				S_EVAL: begin
					if (!ent_v || ent_leaf || (level_q == LVL_PAGE)) begin
						state_q <= S_DONE;
					end else begin
						level_q <= level_q - LVL_W'(1);
						state_q <= S_LOOKUP;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Walk payload and result. A write item and every fault give a zero address
	// and level; only a fault sets the fault flag.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_fire) begin
			va_q        <= virt_addr;
			table_q     <= root_ppn_q;
			res_pa_q    <= '0;
			res_fault_q <= 1'b0;
			res_lvl_q   <= LVL_PAGE;
		end
		if ((state_q == S_LOOKUP) && !in_win) begin
			res_pa_q    <= '0;
			res_fault_q <= 1'b1;
			res_lvl_q   <= LVL_PAGE;
		end
		if (state_q == S_EVAL) begin
			if (ent_v && ent_leaf) begin
				res_pa_q    <= leaf_pa;
				res_fault_q <= 1'b0;
				res_lvl_q   <= level_q;
			end else if (!ent_v || (level_q == LVL_PAGE)) begin
				res_pa_q    <= '0;
				res_fault_q <= 1'b1;
				res_lvl_q   <= LVL_PAGE;
			end else begin
				table_q <= mem_rdata[53:10];
			end
		end
		if (out_load) begin
			phys_addr_q  <= res_pa_q;
			fault_q      <= res_fault_q;
			leaf_level_q <= res_lvl_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign phys_addr  = phys_addr_q;
	assign fault      = fault_q;
	assign leaf_level = leaf_level_q;

endmodule
